// ----- rtl/fcs_pkg.sv -----
// Shared types and codes for the FIFO ready-queue CPU scheduler.
`timescale 1ns / 1ps

package fcs_pkg;

  localparam int PID_W   = 5;
  localparam int CPU_W   = 3;
  localparam int OP_W    = 3;
  localparam int QCNT_W  = 6;
  localparam int ACPU_W  = 4;

  // Event codes
  localparam logic [OP_W-1:0] OP_IDLE    = 3'd0;
  localparam logic [OP_W-1:0] OP_PREEMPT = 3'd1;
  localparam logic [OP_W-1:0] OP_YIELD   = 3'd2;
  localparam logic [OP_W-1:0] OP_TERM    = 3'd3;
  localparam logic [OP_W-1:0] OP_WAKE    = 3'd4;

  // State reported for the outgoing or woken process
  localparam logic [1:0] PST_READY = 2'd0;
  localparam logic [1:0] PST_WAIT  = 2'd1;
  localparam logic [1:0] PST_TERM  = 2'd2;
  localparam logic [1:0] PST_NONE  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_CPU    = 2'd1;
  localparam logic [1:0] ERR_NOCUR  = 2'd2;
  localparam logic [1:0] ERR_FULL   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [CPU_W-1:0] cpu_index;
    logic [PID_W-1:0] process_id;
  } in_t;

  typedef struct packed {
    logic              switch_issued;
    logic [CPU_W-1:0]  switch_cpu;
    logic              run_is_idle;
    logic [PID_W-1:0]  run_process;
    logic [PID_W-1:0]  old_process;
    logic [1:0]        old_state;
    logic [QCNT_W-1:0] queue_count;
    logic [1:0]        error_code;
  } out_t;

endpackage

// ----- rtl/fifo_cpu_scheduler.sv -----
// Top level of the FIFO ready-queue CPU scheduler.
`timescale 1ns / 1ps

// Each event is handled in order: on transfer in, the head of the ready queue is
// read from its synchronous memory; in the execute state the queue, the per-CPU
// run table and the result register are updated. A new event is taken only once
// the previous one has left the execute state, and that state holds while an
// earlier result is still waiting to be taken, so the block never takes a new
// event before it is through with the last one. No clearing pass follows reset:
// queue entries are read on every transfer in, but only used after they were written.
module fifo_cpu_scheduler #(
  parameter int PROCESS_SLOTS = 32,
  parameter int CPU_SLOTS     = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fcs_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fcs_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fcs_pkg::ACPU_W-1:0] cfg_data
);
  import fcs_pkg::*;

  localparam int PTR_W = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int CNT_W = $clog2(PROCESS_SLOTS + 1);
  localparam int CIX_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PROCESS_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PROCESS_SLOTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state;
  in_t               req;
  logic [ACPU_W-1:0] active_cpus;

  logic [PTR_W-1:0]  fifo_head, fifo_tail;
  logic [CNT_W-1:0]  fifo_count;
  logic [PID_W-1:0]  fifo_mem [PROCESS_SLOTS];
  logic [PID_W-1:0]  rd_pid;

  logic              run_valid [CPU_SLOTS];
  logic [PID_W-1:0]  run_pid   [CPU_SLOTS];

  // Execute-cycle decode
  logic              exec_go;
  logic [CIX_W-1:0]  cpu_idx;
  logic              cpu_bad, q_full, q_empty;
  logic              cur_valid;
  logic [PID_W-1:0]  cur_pid;
  logic              do_push, do_pop, do_disp, disp_avail;
  logic [PID_W-1:0]  push_pid, disp_pid;
  logic [CNT_W-1:0]  count_next;
  out_t              res;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign exec_go   = (state == S_EXEC) && (!out_valid || out_ready);

  assign cpu_idx   = CIX_W'(req.cpu_index);
  assign cur_valid = run_valid[cpu_idx];
  assign cur_pid   = run_pid[cpu_idx];
  assign q_full    = (fifo_count == CNT_FULL);
  assign q_empty   = (fifo_count == '0);
  assign cpu_bad   = ({1'b0, req.cpu_index} >= active_cpus) ||
                     ({29'd0, req.cpu_index} >= 32'(CPU_SLOTS));

  always_comb begin
    res           = '0;
    res.old_state = PST_NONE;
    res.error_code = ERR_OK;
    do_push       = 1'b0;
    do_disp       = 1'b0;
    push_pid      = req.process_id;
    unique case (req.opcode)
      OP_WAKE: begin
        if (q_full) begin
          res.error_code = ERR_FULL;
        end else begin
          do_push         = 1'b1;
          res.old_process = req.process_id;
          res.old_state   = PST_READY;
        end
      end
      OP_IDLE, OP_PREEMPT, OP_YIELD, OP_TERM: begin
        if (cpu_bad) begin
          res.error_code = ERR_CPU;
        end else if (req.opcode == OP_IDLE) begin
          do_disp = !q_empty;
        end else if (!cur_valid) begin
          res.error_code = ERR_NOCUR;
        end else if (req.opcode == OP_PREEMPT) begin
          if (q_full) begin
            res.error_code = ERR_FULL;
          end else begin
            do_push         = 1'b1;
            push_pid        = cur_pid;
            res.old_process = cur_pid;
            res.old_state   = PST_READY;
            do_disp         = 1'b1;
          end
        end else begin
          res.old_process = cur_pid;
          res.old_state   = (req.opcode == OP_YIELD) ? PST_WAIT : PST_TERM;
          do_disp         = 1'b1;
        end
      end
      default: ;
    endcase

    // A preempt on an empty queue dispatches the process it just requeued.
    disp_avail = !q_empty || do_push;
    disp_pid   = q_empty ? cur_pid : rd_pid;
    do_pop     = do_disp && disp_avail;
    if (do_disp) begin
      res.switch_issued = 1'b1;
      res.switch_cpu    = req.cpu_index;
      res.run_is_idle   = !disp_avail;
      res.run_process   = disp_avail ? disp_pid : '0;
    end
    count_next      = fifo_count + CNT_W'(do_push) - CNT_W'(do_pop);
    res.queue_count = QCNT_W'(count_next);
  end

  // Queue storage: read the head on transfer in, write the tail on execute.
  always_ff @(posedge clk) begin
    if (exec_go && do_push) begin
      fifo_mem[fifo_tail] <= push_pid;
    end
    if (in_valid && in_ready) begin
      rd_pid <= fifo_mem[fifo_head];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (exec_go) begin
      out_data <= res;
      if (do_disp) begin
        run_pid[cpu_idx] <= disp_pid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      active_cpus <= ACPU_W'(1);
      fifo_head   <= '0;
      fifo_tail   <= '0;
      fifo_count  <= '0;
      for (int i = 0; i < CPU_SLOTS; i++) begin
        run_valid[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_cpus <= cfg_data;
      end
      if (out_valid && out_ready && !exec_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state      <= S_IDLE;
            out_valid  <= 1'b1;
            fifo_count <= count_next;
            if (do_push) begin
              fifo_tail <= (fifo_tail == PTR_LAST) ? '0 : fifo_tail + 1'b1;
            end
            if (do_pop) begin
              fifo_head <= (fifo_head == PTR_LAST) ? '0 : fifo_head + 1'b1;
            end
            if (do_disp) begin
              run_valid[cpu_idx] <= disp_avail;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/fcs_checker.sv -----
// Port-level checks for the FIFO ready-queue CPU scheduler, bound to the top level.
`timescale 1ns / 1ps

module fcs_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input fcs_pkg::out_t out_data
);
  import fcs_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One event at a time: no transfer in right after a transfer in.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second event taken while one is in flight");

  // No switch leaves the run fields clear.
  a_no_switch_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.switch_issued |->
      out_data.switch_cpu == '0 && !out_data.run_is_idle && out_data.run_process == '0)
    else $error("run fields set without a switch");

  // A rejected event changes nothing.
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_code != ERR_OK |->
      !out_data.switch_issued && out_data.old_state == PST_NONE)
    else $error("rejected event reported a change");

endmodule

bind fifo_cpu_scheduler fcs_checker u_fcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/tb_fifo_cpu_scheduler.sv -----
// Testbench for the FIFO ready-queue CPU scheduler: directed and random events against a predictor.
`timescale 1ns / 1ps

module tb_fifo_cpu_scheduler;
  import fcs_pkg::*;

  localparam int PROCESS_SLOTS = 32;
  localparam int CPU_SLOTS     = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_LIMIT   = 40;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ACPU_W-1:0] cfg_data  = '0;

  // Scheduler state as the predictor sees it
  logic [PID_W-1:0]     ready_ring [PROCESS_SLOTS];
  int                   ring_head  = 0;
  int                   ring_tail  = 0;
  int                   ring_count = 0;
  logic [CPU_SLOTS-1:0] run_valid  = '0;
  logic [PID_W-1:0]     run_pid    [CPU_SLOTS];
  logic [ACPU_W-1:0]    cpu_limit  = 4'd1;

  out_t scheduled_reports [$];
  int   error_count  = 0;
  int   report_index = 0;
  int   cycle_count  = 0;
  int   gap_pct      = 0;
  int   stall_pct    = 0;

  fifo_cpu_scheduler #(
    .PROCESS_SLOTS(PROCESS_SLOTS),
    .CPU_SLOTS    (CPU_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void enqueue_pid(logic [PID_W-1:0] pid);
    ready_ring[ring_tail] = pid;
    ring_tail = (ring_tail + 1) % PROCESS_SLOTS;
    ring_count++;
  endfunction

  // Put the queue head on the CPU, or the idle process when the queue is empty.
  function automatic out_t dispatch_head(logic [CPU_W-1:0] cpu, out_t r);
    r.switch_issued = 1'b1;
    r.switch_cpu    = cpu;
    if (ring_count == 0) begin
      run_valid[cpu] = 1'b0;
      run_pid[cpu]   = '0;
      r.run_is_idle  = 1'b1;
      r.run_process  = '0;
    end else begin
      run_valid[cpu] = 1'b1;
      run_pid[cpu]   = ready_ring[ring_head];
      ring_head      = (ring_head + 1) % PROCESS_SLOTS;
      ring_count--;
      r.run_is_idle  = 1'b0;
      r.run_process  = run_pid[cpu];
    end
    return r;
  endfunction

  function automatic out_t schedule_event(in_t ev);
    out_t r;
    logic full;
    r           = '0;
    r.old_state = PST_NONE;
    r.error_code = ERR_OK;
    full        = (ring_count >= PROCESS_SLOTS);
    if (ev.opcode == OP_WAKE) begin
      if (full) begin
        r.error_code = ERR_FULL;
      end else begin
        enqueue_pid(ev.process_id);
        r.old_process = ev.process_id;
        r.old_state   = PST_READY;
      end
    end else if (ev.opcode <= OP_TERM) begin
      if ({1'b0, ev.cpu_index} >= cpu_limit) begin
        r.error_code = ERR_CPU;
      end else if (ev.opcode == OP_IDLE) begin
        if (ring_count != 0) r = dispatch_head(ev.cpu_index, r);
      end else if (!run_valid[ev.cpu_index]) begin
        r.error_code = ERR_NOCUR;
      end else if (ev.opcode == OP_PREEMPT) begin
        if (full) begin
          r.error_code = ERR_FULL;
        end else begin
          r.old_process = run_pid[ev.cpu_index];
          r.old_state   = PST_READY;
          enqueue_pid(run_pid[ev.cpu_index]);
          r = dispatch_head(ev.cpu_index, r);
        end
      end else begin
        r.old_process = run_pid[ev.cpu_index];
        r.old_state   = (ev.opcode == OP_YIELD) ? PST_WAIT : PST_TERM;
        r = dispatch_head(ev.cpu_index, r);
      end
    end
    r.queue_count = ring_count[QCNT_W-1:0];
    return r;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d: %s is %0d, expected %0d", report_index, name, got,
                           want));
    end
  endtask

  always @(posedge clk) begin : check_reports
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (scheduled_reports.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no event pending", report_index));
      end else begin
        want = scheduled_reports.pop_front();
        check_field("switch_issued", 8'(out_data.switch_issued), 8'(want.switch_issued));
        check_field("switch_cpu", 8'(out_data.switch_cpu), 8'(want.switch_cpu));
        check_field("run_is_idle", 8'(out_data.run_is_idle), 8'(want.run_is_idle));
        check_field("run_process", 8'(out_data.run_process), 8'(want.run_process));
        check_field("old_process", 8'(out_data.old_process), 8'(want.old_process));
        check_field("old_state", 8'(out_data.old_state), 8'(want.old_state));
        check_field("queue_count", 8'(out_data.queue_count), 8'(want.queue_count));
        check_field("error_code", 8'(out_data.error_code), 8'(want.error_code));
      end
      report_index++;
    end
  end

  // Hold valid across back-to-back events; drop it only for a gap.
  task automatic post_event(logic [OP_W-1:0] op, logic [CPU_W-1:0] cpu,
                            logic [PID_W-1:0] pid);
    in_t ev;
    ev.opcode     = op;
    ev.cpu_index  = cpu;
    ev.process_id = pid;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    scheduled_reports.push_back(schedule_event(ev));
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (scheduled_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_cpus(logic [ACPU_W-1:0] n);
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cpu_limit = n;
  endtask

  // One CPU in use after reset.
  task automatic test_basic_dispatch();
    gap_pct   = 0;
    stall_pct = 0;
    post_event(OP_IDLE, 3'd0, 5'd0);
    post_event(OP_PREEMPT, 3'd0, 5'd31);
    post_event(OP_YIELD, 3'd0, 5'd0);
    post_event(OP_TERM, 3'd0, 5'd0);
    post_event(OP_IDLE, 3'd1, 5'd0);
    post_event(3'd5, 3'd0, 5'd0);
    post_event(3'd6, 3'd3, 5'd10);
    post_event(3'd7, 3'd7, 5'd31);
    post_event(OP_WAKE, 3'd7, 5'd0);
    post_event(OP_WAKE, 3'd0, 5'd31);
    post_event(OP_WAKE, 3'd0, 5'd31);
    post_event(OP_IDLE, 3'd0, 5'd0);
    // running process is dropped without a state report
    post_event(OP_IDLE, 3'd0, 5'd0);
    post_event(OP_IDLE, 3'd0, 5'd0);
    // queue is empty here: the same process goes straight back on
    post_event(OP_PREEMPT, 3'd0, 5'd0);
    post_event(OP_YIELD, 3'd0, 5'd0);
    post_event(OP_WAKE, 3'd2, 5'd5);
    post_event(OP_WAKE, 3'd0, 5'd17);
    post_event(OP_IDLE, 3'd0, 5'd0);
    post_event(OP_TERM, 3'd0, 5'd0);
    post_event(OP_TERM, 3'd0, 5'd0);
    post_event(OP_YIELD, 3'd7, 5'd0);
  endtask

  task automatic test_cpu_range();
    set_active_cpus(4'd0);
    post_event(OP_IDLE, 3'd0, 5'd0);
    post_event(OP_WAKE, 3'd0, 5'd12);
    post_event(OP_YIELD, 3'd7, 5'd0);
    set_active_cpus(4'd15);
    post_event(OP_IDLE, 3'd7, 5'd0);
    post_event(OP_TERM, 3'd7, 5'd0);
  endtask

  task automatic test_queue_full();
    set_active_cpus(4'd8);
    gap_pct   = 30;
    stall_pct = 30;
    post_event(OP_WAKE, 3'd0, 5'd9);
    post_event(OP_IDLE, 3'd2, 5'd0);
    repeat (PROCESS_SLOTS) begin
      post_event(OP_WAKE, CPU_W'($urandom_range(7)), PID_W'($urandom_range(31)));
    end
    post_event(OP_WAKE, 3'd5, 5'd31);
    post_event(OP_PREEMPT, 3'd2, 5'd0);
    post_event(OP_IDLE, 3'd7, 5'd0);
    post_event(OP_PREEMPT, 3'd2, 5'd0);
    repeat (PROCESS_SLOTS + 2) begin
      post_event($urandom_range(1) ? OP_IDLE : OP_TERM, CPU_W'($urandom_range(7)),
                 PID_W'($urandom_range(31)));
    end
  endtask

  task automatic test_random_traffic(int count, logic [ACPU_W-1:0] cpus, int gap, int stall);
    int               wake_w;
    int               pick;
    int               top;
    logic [OP_W-1:0]  op;
    logic [CPU_W-1:0] cpu;
    set_active_cpus(cpus);
    gap_pct   = gap;
    stall_pct = stall;
    top = (cpus == 0) ? 0 : ((cpus > CPU_SLOTS) ? CPU_SLOTS : cpus) - 1;
    repeat (count) begin
      // steer the queue between empty and full
      wake_w = (ring_count < 4) ? 60 : ((ring_count > 26) ? 20 : 40);
      pick   = $urandom_range(99);
      if (pick < 3) op = OP_W'($urandom_range(7, 5));
      else if (pick < 3 + wake_w) op = OP_WAKE;
      else op = OP_W'($urandom_range(3, 0));
      cpu = ($urandom_range(9) == 0) ? CPU_W'($urandom_range(7)) : CPU_W'($urandom_range(top));
      post_event(op, cpu, PID_W'($urandom_range(PROCESS_SLOTS - 1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_dispatch();
    test_cpu_range();
    test_queue_full();
    test_random_traffic(250, 4'd8, 0, 0);
    test_random_traffic(250, 4'd4, 68, 0);
    test_random_traffic(250, 4'd15, 0, 68);
    test_random_traffic(250, 4'd1, 7, 7);
    drain_reports();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
